// File: hdl/latlon_to_cube_face_coords_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef LATLON_TO_CUBE_FACE_COORDS_TOP_DEFINES_SVH
`define LATLON_TO_CUBE_FACE_COORDS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LCF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/lcf_pkg.sv
`timescale 1ns / 1ps

package lcf_pkg;

    // fixed point formats
    localparam int ANGLE_FRAC_BITS = 22;
    localparam int COORD_FRAC_BITS = 24;
    localparam int ANGLE_W         = 32;
    localparam int HINT_W          = 4;
    localparam int FACE_W          = 3;
    localparam int COORD_W         = 27;

    // one quarter turn, its square and half its square
    localparam longint ANG_D  = longint'(90) << ANGLE_FRAC_BITS;
    localparam longint ANG_D2 = ANG_D * ANG_D;
    localparam longint ANG_H  = ANG_D2 / 2;

    // datapath widths
    localparam int L_W   = $clog2(2 * ANG_D + 1);
    localparam int G_W   = $clog2(4 * ANG_D + 1);
    localparam int MA_W  = $clog2(7 * ANG_D + 1) + 1;
    localparam int MB_W  = L_W + 1;
    localparam int C_W   = L_W + 1;
    localparam int NUM_W = $clog2(15 * ANG_D2) + 1;
    localparam int MAG_W = NUM_W - 1;

    // numerator / (8100 * 2^(2A-C)) == (numerator >> (2A-C+2)) / 2025
    localparam int     DIV_SHIFT = 2 * ANGLE_FRAC_BITS - COORD_FRAC_BITS + 2;
    localparam int     DIV_K     = 2025;
    localparam int     Q_W       = COORD_W - 1;
    localparam longint N_LIMIT   = longint'(DIV_K) << Q_W;
    localparam int     N_W       = $clog2(N_LIMIT);
    localparam int     NRAW_W    = MAG_W - DIV_SHIFT;
    localparam int     NHI_W     = 32;
    localparam int     NLO_W     = N_W - NHI_W;
    localparam int     RECIP_SH  = 38;
    localparam longint RECIP     = (longint'(1) << (RECIP_SH + NLO_W)) / DIV_K;
    localparam int     RECIP_W   = $clog2(RECIP + 1);
    localparam int     LIM_W     = N_W + 1;

    // pipeline shape
    localparam int FRONT_STAGES = 4;
    localparam int SCALE_STAGES = 4;
    localparam int N_STAGES     = FRONT_STAGES + SCALE_STAGES;

    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef logic signed [HINT_W-1:0]  t_hint;
    typedef logic [FACE_W-1:0]         t_face;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [NUM_W-1:0]   t_num;
    typedef logic [FRONT_STAGES-1:0]   t_front_en;
    typedef logic [SCALE_STAGES-1:0]   t_scale_en;

    // face codes
    localparam t_face FACE_NORTH = 3'd4;
    localparam t_face FACE_SOUTH = 3'd5;
    localparam t_face FACE_LAST  = FACE_SOUTH;

    // saturation limits
    localparam t_coord COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // how one face coordinate is built from the two products
    typedef struct packed {
        logic use_p2;
        logic neg;
        logic add_h;
    } t_term_sel;

    // front end result handed to the scalers
    typedef struct packed {
        logic  ok;
        t_face face;
        t_num  num_x;
        t_num  num_y;
    } t_front_out;

endpackage

// File: hdl/lcf_in_if.sv
`timescale 1ns / 1ps

interface lcf_in_if;
    import lcf_pkg::*;

    logic   valid;
    logic   ready;
    t_angle latitude;
    t_angle longitude;
    t_hint  face_hint;

    modport source (output valid, latitude, longitude, face_hint, input ready);
    modport sink   (input valid, latitude, longitude, face_hint, output ready);
endinterface

// File: hdl/lcf_out_if.sv
`timescale 1ns / 1ps

interface lcf_out_if;
    import lcf_pkg::*;

    logic   valid;
    logic   ready;
    logic   ok;
    t_face  face;
    t_coord face_x;
    t_coord face_y;

    modport source (output valid, ok, face, face_x, face_y, input ready);
    modport sink   (input valid, ok, face, face_x, face_y, output ready);
endinterface

// File: hdl/lcf_front.sv
`timescale 1ns / 1ps

module lcf_front (
    input  logic                i_clk,
    input  lcf_pkg::t_front_en  i_en,
    input  lcf_pkg::t_angle     i_latitude,
    input  lcf_pkg::t_angle     i_longitude,
    input  lcf_pkg::t_hint      i_face_hint,
    output lcf_pkg::t_front_out o_front
);
    import lcf_pkg::*;

    localparam t_angle           LAT_MAX = t_angle'(ANG_D);
    localparam t_angle           LAT_MIN = t_angle'(-ANG_D);
    localparam t_angle           LON_MAX = t_angle'(2 * ANG_D);
    localparam t_angle           LON_MIN = t_angle'(-2 * ANG_D);
    localparam logic [G_W-1:0]   G_D1    = G_W'(ANG_D);
    localparam logic [G_W-1:0]   G_D2    = G_W'(2 * ANG_D);
    localparam logic [G_W-1:0]   G_D3    = G_W'(3 * ANG_D);
    localparam logic [L_W-1:0]   L_HALF  = L_W'(ANG_D / 2);
    localparam logic [L_W-1:0]   L_3HALF = L_W'(3 * ANG_D / 2);
    localparam t_num             NUM_H   = NUM_W'(ANG_H);

    // stage 1: range check and offset angles
    logic             n_s1_ok;
    logic [L_W-1:0]   n_s1_l;
    logic [G_W-1:0]   n_s1_g;
    logic             n_s1_hint_vld;
    logic             r_s1_ok;
    logic [L_W-1:0]   r_s1_l;
    logic [G_W-1:0]   r_s1_g;
    logic             r_s1_hint_vld;
    t_face            r_s1_hint;

    assign n_s1_ok = (i_latitude >= LAT_MIN) && (i_latitude <= LAT_MAX) &&
                     (i_longitude >= LON_MIN) && (i_longitude <= LON_MAX);
    assign n_s1_l  = L_W'(i_latitude + LAT_MAX);
    assign n_s1_g  = G_W'(i_longitude + LON_MAX);
    assign n_s1_hint_vld = !i_face_hint[HINT_W-1] && (i_face_hint[FACE_W-1:0] <= FACE_LAST);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_ok       <= n_s1_ok;
            r_s1_l        <= n_s1_l;
            r_s1_g        <= n_s1_g;
            r_s1_hint_vld <= n_s1_hint_vld;
            r_s1_hint     <= i_face_hint[FACE_W-1:0];
        end
    end

    // stage 2: face and band decision, multiplier operands
    logic [1:0]              w_band_pos;
    logic [1:0]              n_s2_band;
    t_face                   n_s2_face;
    logic signed [MA_W-1:0]  w_g_s;
    logic signed [MA_W-1:0]  w_u [4];
    logic signed [MA_W-1:0]  w_w [4];
    logic signed [C_W-1:0]   w_l_s;
    logic signed [C_W-1:0]   w_p;
    logic signed [MA_W-1:0]  n_s2_ma;
    logic signed [MB_W-1:0]  n_s2_mb;
    logic signed [C_W-1:0]   n_s2_c;
    logic signed [MA_W-1:0]  r_s2_ma;
    logic signed [MB_W-1:0]  r_s2_mb;
    logic signed [C_W-1:0]   r_s2_c;
    t_face                   r_s2_face;
    logic [1:0]              r_s2_band;
    logic                    r_s2_ok;

    // longitude band, longitude 180 folds into the last band
    always_comb begin
        if (r_s1_g >= G_D3) begin
            w_band_pos = 2'd3;
        end else if (r_s1_g >= G_D2) begin
            w_band_pos = 2'd2;
        end else if (r_s1_g >= G_D1) begin
            w_band_pos = 2'd1;
        end else begin
            w_band_pos = 2'd0;
        end
    end

    // a valid hint forces the face, an equatorial hint also the band
    always_comb begin
        n_s2_band = w_band_pos;
        if (r_s1_hint_vld) begin
            n_s2_face = r_s1_hint;
            if (r_s1_hint < FACE_NORTH) begin
                n_s2_band = r_s1_hint[1:0];
            end
        end else if (r_s1_l < L_HALF) begin
            n_s2_face = FACE_SOUTH;
        end else if (r_s1_l >= L_3HALF) begin
            n_s2_face = FACE_NORTH;
        end else begin
            n_s2_face = t_face'(w_band_pos);
        end
        if (!r_s1_ok) begin
            n_s2_face = '0;
        end
    end

    // in-band offset and its doubled form, one candidate per band
    assign w_g_s = MA_W'({1'b0, r_s1_g});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_u[k] = w_g_s - MA_W'(longint'(k) * ANG_D);
            w_w[k] = (w_g_s <<< 1) - MA_W'((2 * longint'(k) + 1) * ANG_D);
        end
    end

    assign w_l_s = C_W'({1'b0, r_s1_l});
    assign w_p   = (n_s2_face == FACE_NORTH) ? (C_W'(2 * ANG_D) - w_l_s) : w_l_s;

    always_comb begin
        if (n_s2_face == FACE_NORTH || n_s2_face == FACE_SOUTH) begin
            n_s2_ma = w_w[n_s2_band];
            n_s2_mb = MB_W'(w_p);
            n_s2_c  = w_p;
        end else begin
            n_s2_ma = w_u[n_s2_band];
            n_s2_mb = MB_W'(ANG_D);
            n_s2_c  = w_l_s - C_W'(ANG_D / 2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s2_ma   <= n_s2_ma;
            r_s2_mb   <= n_s2_mb;
            r_s2_c    <= n_s2_c;
            r_s2_face <= n_s2_face;
            r_s2_band <= n_s2_band;
            r_s2_ok   <= r_s1_ok;
        end
    end

    // stage 3: products and per-axis term selection
    logic signed [MA_W+MB_W-1:0] w_p1;
    t_num                        w_p2;
    t_term_sel                   n_s3_sel_x;
    t_term_sel                   n_s3_sel_y;
    t_num                        r_s3_p1;
    t_num                        r_s3_p2;
    t_term_sel                   r_s3_sel_x;
    t_term_sel                   r_s3_sel_y;
    t_face                       r_s3_face;
    logic                        r_s3_ok;

    assign w_p1 = r_s2_ma * r_s2_mb;
    assign w_p2 = NUM_W'(r_s2_c) * NUM_W'(ANG_D);

    // polar caps rotate by band; equatorial faces take the products as they are
    always_comb begin
        n_s3_sel_x = '{use_p2: 1'b0, neg: 1'b0, add_h: 1'b0};
        n_s3_sel_y = '{use_p2: 1'b1, neg: 1'b0, add_h: 1'b0};
        if (r_s2_face == FACE_NORTH) begin
            case (r_s2_band)
                2'd0: begin
                    n_s3_sel_x = '{use_p2: 1'b0, neg: 1'b0, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b1, neg: 1'b1, add_h: 1'b1};
                end
                2'd1: begin
                    n_s3_sel_x = '{use_p2: 1'b1, neg: 1'b0, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b0, neg: 1'b0, add_h: 1'b1};
                end
                2'd2: begin
                    n_s3_sel_x = '{use_p2: 1'b0, neg: 1'b1, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b1, neg: 1'b0, add_h: 1'b1};
                end
                default: begin
                    n_s3_sel_x = '{use_p2: 1'b1, neg: 1'b1, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b0, neg: 1'b1, add_h: 1'b1};
                end
            endcase
        end else if (r_s2_face == FACE_SOUTH) begin
            case (r_s2_band)
                2'd0: begin
                    n_s3_sel_x = '{use_p2: 1'b1, neg: 1'b1, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b0, neg: 1'b0, add_h: 1'b1};
                end
                2'd1: begin
                    n_s3_sel_x = '{use_p2: 1'b0, neg: 1'b0, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b1, neg: 1'b0, add_h: 1'b1};
                end
                2'd2: begin
                    n_s3_sel_x = '{use_p2: 1'b1, neg: 1'b0, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b0, neg: 1'b1, add_h: 1'b1};
                end
                default: begin
                    n_s3_sel_x = '{use_p2: 1'b0, neg: 1'b1, add_h: 1'b1};
                    n_s3_sel_y = '{use_p2: 1'b1, neg: 1'b1, add_h: 1'b1};
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s3_p1    <= NUM_W'(w_p1);
            r_s3_p2    <= w_p2;
            r_s3_sel_x <= n_s3_sel_x;
            r_s3_sel_y <= n_s3_sel_y;
            r_s3_face  <= r_s2_face;
            r_s3_ok    <= r_s2_ok;
        end
    end

    // stage 4: numerators over the squared quarter turn
    function automatic t_num f_numer(t_term_sel s, t_num p1, t_num p2);
        t_num t;
        t_num off;
        t   = s.use_p2 ? p2 : p1;
        off = s.add_h ? NUM_H : '0;
        return off + (s.neg ? ~t : t) + NUM_W'(s.neg);
    endfunction

    t_front_out n_s4;
    t_front_out r_s4;

    always_comb begin
        n_s4.ok    = r_s3_ok;
        n_s4.face  = r_s3_face;
        n_s4.num_x = r_s3_ok ? f_numer(r_s3_sel_x, r_s3_p1, r_s3_p2) : '0;
        n_s4.num_y = r_s3_ok ? f_numer(r_s3_sel_y, r_s3_p1, r_s3_p2) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s4 <= n_s4;
        end
    end

    assign o_front = r_s4;

endmodule

// File: hdl/lcf_scale.sv
`timescale 1ns / 1ps

module lcf_scale (
    input  logic               i_clk,
    input  lcf_pkg::t_scale_en i_en,
    input  lcf_pkg::t_num      i_num,
    output lcf_pkg::t_coord    o_coord
);
    import lcf_pkg::*;

    // stage 5: sign and magnitude, drop the low bits, flag saturation
    logic                  w_neg;
    logic [MAG_W-1:0]      w_mag;
    logic [NRAW_W-1:0]     w_nraw;
    logic                  w_sat;
    logic [N_W-1:0]        r_s5_n;
    logic                  r_s5_neg;
    logic                  r_s5_sat;

    assign w_neg  = i_num[NUM_W-1];
    assign w_mag  = MAG_W'(w_neg ? -i_num : i_num);
    assign w_nraw = w_mag[MAG_W-1:DIV_SHIFT];
    assign w_sat  = w_nraw >= NRAW_W'(N_LIMIT);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s5_n   <= w_sat ? '0 : w_nraw[N_W-1:0];
            r_s5_neg <= w_neg;
            r_s5_sat <= w_sat;
        end
    end

    // stage 6: quotient estimate by reciprocal, low by at most one
    logic [NHI_W+RECIP_W-1:0] w_q_prod;
    logic [Q_W-1:0]           r_s6_q0;
    logic [N_W-1:0]           r_s6_n;
    logic                     r_s6_neg;
    logic                     r_s6_sat;

    assign w_q_prod = r_s5_n[N_W-1 -: NHI_W] * RECIP_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s6_q0  <= w_q_prod[RECIP_SH +: Q_W];
            r_s6_n   <= r_s5_n;
            r_s6_neg <= r_s5_neg;
            r_s6_sat <= r_s5_sat;
        end
    end

    // stage 7: dividend bound for the next quotient value
    logic [LIM_W-1:0] w_lim;
    logic [LIM_W-1:0] r_s7_lim;
    logic [Q_W-1:0]   r_s7_q0;
    logic [N_W-1:0]   r_s7_n;
    logic             r_s7_neg;
    logic             r_s7_sat;

    assign w_lim = LIM_W'({1'b0, r_s6_q0} + 1'b1) * LIM_W'(DIV_K);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_s7_lim <= w_lim;
            r_s7_q0  <= r_s6_q0;
            r_s7_n   <= r_s6_n;
            r_s7_neg <= r_s6_neg;
            r_s7_sat <= r_s6_sat;
        end
    end

    // stage 8: correct, apply sign, saturate
    logic   w_up;
    t_coord w_q_ext;
    t_coord n_s8_coord;
    t_coord r_s8_coord;

    assign w_up    = LIM_W'(r_s7_n) >= r_s7_lim;
    assign w_q_ext = COORD_W'({1'b0, r_s7_q0});

    always_comb begin
        if (r_s7_sat) begin
            n_s8_coord = r_s7_neg ? COORD_MIN : COORD_MAX;
        end else if (r_s7_neg) begin
            n_s8_coord = ~w_q_ext + COORD_W'(!w_up);
        end else begin
            n_s8_coord = w_q_ext + COORD_W'(w_up);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_s8_coord <= n_s8_coord;
        end
    end

    assign o_coord = r_s8_coord;

endmodule

// File: hdl/latlon_to_cube_face_coords_top.sv
// throughput: one word per cycle while o_res is not stalled, through eight register stages; the widest steps
// are the 33 x 31 bit coordinate product and the 32 x 33 bit reciprocal product
// a stalled result holds in the last stage while empty stages upstream keep filling
// reset (i_rst_n low, synchronous) clears the stage valid bits; data is not reset
`timescale 1ns / 1ps
`include "latlon_to_cube_face_coords_top_defines.svh"

module latlon_to_cube_face_coords_top (
    input logic        i_clk,
    input logic        i_rst_n,
    lcf_in_if.sink     i_pt,
    lcf_out_if.source  o_res
);
    import lcf_pkg::*;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] n_vld;
    logic [N_STAGES-1:0] w_en;
    t_front_out          w_front;
    t_coord              w_coord_x;
    t_coord              w_coord_y;
    t_face               r_face_d [SCALE_STAGES];
    logic                r_ok_d   [SCALE_STAGES];

    // a stage moves when it is empty or the next stage moves
    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || o_res.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // valid bits follow the data
    always_comb begin
        n_vld[0] = w_en[0] ? i_pt.valid : r_vld[0];
        for (int k = 1; k < N_STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pt.ready = w_en[0];

    // angle decode, face choice and numerators
    lcf_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en[FRONT_STAGES-1:0]),
        .i_latitude  (i_pt.latitude),
        .i_longitude (i_pt.longitude),
        .i_face_hint (i_pt.face_hint),
        .o_front     (w_front)
    );

    // scaling of each numerator to a face coordinate
    lcf_scale u_scale_x (
        .i_clk   (i_clk),
        .i_en    (w_en[N_STAGES-1:FRONT_STAGES]),
        .i_num   (w_front.num_x),
        .o_coord (w_coord_x)
    );

    lcf_scale u_scale_y (
        .i_clk   (i_clk),
        .i_en    (w_en[N_STAGES-1:FRONT_STAGES]),
        .i_num   (w_front.num_y),
        .o_coord (w_coord_y)
    );

    // face and status ride alongside the scalers
    always_ff @(posedge i_clk) begin
        if (w_en[FRONT_STAGES]) begin
            r_face_d[0] <= w_front.face;
            r_ok_d[0]   <= w_front.ok;
        end
        for (int k = 1; k < SCALE_STAGES; k++) begin
            if (w_en[FRONT_STAGES+k]) begin
                r_face_d[k] <= r_face_d[k-1];
                r_ok_d[k]   <= r_ok_d[k-1];
            end
        end
    end

    assign o_res.valid  = r_vld[N_STAGES-1];
    assign o_res.ok     = r_ok_d[SCALE_STAGES-1];
    assign o_res.face   = r_face_d[SCALE_STAGES-1];
    assign o_res.face_x = w_coord_x;
    assign o_res.face_y = w_coord_y;

    // out-of-range words carry all-zero fields
    `LCF_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_res.valid && !o_res.ok, o_res.face == '0 && o_res.face_x == '0 && o_res.face_y == '0, "out-of-range word with nonzero fields")
    // a full pipe with a stalled output takes no new word
    `LCF_ASSERT_NOW(a_full_stall, i_clk, i_rst_n, (&r_vld) && !o_res.ready, !i_pt.ready, "word accepted into a full stalled pipe")
    // an accepted word lands in the first stage
    `LCF_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_pt.valid && i_pt.ready, r_vld[0], "accepted word lost at the first stage")

endmodule
